// ===== rtl/core/timed_event_queue_with_cancel_unit_macros.svh =====
// Assertion helpers for the timed event queue.
`ifndef TIMED_EVENT_QUEUE_WITH_CANCEL_UNIT_MACROS_SVH
`define TIMED_EVENT_QUEUE_WITH_CANCEL_UNIT_MACROS_SVH

`ifndef SYNTH
`define TEQU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TEQU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define TEQU_ASSERT(lbl, prop, msg)
`define TEQU_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/core/tequ_pkg.sv =====
`default_nettype none

package tequ_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned OWNER_W   = 8;
  localparam int unsigned CMD_W     = 16;
  localparam int unsigned TAG_W     = 16;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned COUNT_W   = 5;

  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned FIRE_W      = $clog2(MAX_RESULTS + 1);

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 2'd0,
    OP_INSERT     = 2'd1,
    OP_CANCEL_CMD = 2'd2,
    OP_CANCEL_ALL = 2'd3
  } in_op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIRED     = 2'd0,
    KIND_INSERT_OK = 2'd1,
    KIND_FULL      = 2'd2,
    KIND_CANCELED  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_POP,
    CELL_DECAY
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_CANCEL,
    ST_DECAY,
    ST_FIRE
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0]  remaining;
    logic [OWNER_W-1:0] owner;
    logic [CMD_W-1:0]   command;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t data;
  } slot_t;

  typedef struct packed {
    in_op_e             op;
    logic [TIME_W-1:0]  delay;
    logic [OWNER_W-1:0] owner;
    logic [CMD_W-1:0]   command;
    logic [TAG_W-1:0]   tag;
  } req_t;

  typedef struct packed {
    cell_op_e op;
    req_t     req;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/timed_event_queue_with_cancel_unit.sv =====
// An insert goes through INSERT to its result; a cancel removes the matching
// events one at a time in CANCEL, then gives its result; a tick goes through
// DECAY, then FIRE pops due events one per cycle unless the output stalls.
// One request at a time; each is taken in idle with the output register empty.
// Reset: asynchronous, active low; empties every slot and the output register.
`default_nettype none
`include "timed_event_queue_with_cancel_unit_macros.svh"

module timed_event_queue_with_cancel_unit #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [15:0] delay_ticks_i,
  input  wire logic [7:0]  owner_id_i,
  input  wire logic [15:0] command_i,
  input  wire logic [15:0] message_tag_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       result_kind_o,
  output logic [7:0]       fired_owner_o,
  output logic [15:0]      fired_command_o,
  output logic [15:0]      fired_tag_o,
  output logic [4:0]       removed_count_o,
  output logic             last_of_run_o
);

  tequ_pkg::state_e   state_q, state_d;
  tequ_pkg::req_t     req_q;
  tequ_pkg::cell_ctl_t ctl;
  tequ_pkg::cell_op_e  cell_op;

  tequ_pkg::slot_t slots [SLOTS];
  logic [SLOTS-1:0] keep;
  logic [SLOTS:0]   hit_chain;
  logic [SLOTS-1:0] slot_vld;

  logic [tequ_pkg::COUNT_W-1:0] rm_cnt_q, rm_cnt_d;
  logic [tequ_pkg::FIRE_W-1:0]  fire_cnt_q, fire_cnt_d;

  logic                           out_valid_q;
  logic [tequ_pkg::KIND_W-1:0]    kind_q;
  logic [tequ_pkg::OWNER_W-1:0]   owner_q;
  logic [tequ_pkg::CMD_W-1:0]     cmd_q;
  logic [tequ_pkg::TAG_W-1:0]     tag_q;
  logic [tequ_pkg::COUNT_W-1:0]   count_q;
  logic                           last_q;

  logic                           out_load;
  tequ_pkg::kind_e                out_kind;
  logic [tequ_pkg::OWNER_W-1:0]   out_owner;
  logic [tequ_pkg::CMD_W-1:0]     out_cmd;
  logic [tequ_pkg::TAG_W-1:0]     out_tag;
  logic [tequ_pkg::COUNT_W-1:0]   out_count;
  logic                           out_last;

  logic in_accept, out_free, head_due, next_due;

  assign in_stall_o = (state_q != tequ_pkg::ST_IDLE) || out_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign hit_chain[0] = 1'b0;
  assign ctl          = '{op: cell_op, req: req_q};

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    tequ_pkg::slot_t left, right;
    logic            prev_keep;
    if (i == 0) begin : g_first
      assign left      = '0;
      assign prev_keep = 1'b1;
    end else begin : g_mid
      assign left      = slots[i-1];
      assign prev_keep = keep[i-1];
    end
    if (i == SLOTS - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = slots[i+1];
    end
    tequ_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .left_i      (left),
      .right_i     (right),
      .prev_keep_i (prev_keep),
      .hit_in_i    (hit_chain[i]),
      .keep_o      (keep[i]),
      .hit_out_o   (hit_chain[i+1]),
      .slot_o      (slots[i])
    );
    assign slot_vld[i] = slots[i].valid;
  end

  assign head_due = slots[0].valid && (slots[0].data.remaining == '0);
  assign next_due = slots[1].valid && (slots[1].data.remaining == '0);

  always_comb begin
    state_d    = state_q;
    cell_op    = tequ_pkg::CELL_HOLD;
    rm_cnt_d   = rm_cnt_q;
    fire_cnt_d = fire_cnt_q;
    out_load   = 1'b0;
    out_kind   = tequ_pkg::KIND_FIRED;
    out_owner  = '0;
    out_cmd    = '0;
    out_tag    = '0;
    out_count  = '0;
    out_last   = 1'b1;
    case (state_q)
      tequ_pkg::ST_IDLE: begin
        rm_cnt_d   = '0;
        fire_cnt_d = '0;
        if (in_accept) begin
          case (tequ_pkg::in_op_e'(operation_i))
            tequ_pkg::OP_TICK:   state_d = tequ_pkg::ST_DECAY;
            tequ_pkg::OP_INSERT: state_d = tequ_pkg::ST_INSERT;
            default:             state_d = tequ_pkg::ST_CANCEL;
          endcase
        end
      end
      tequ_pkg::ST_INSERT: begin
        out_load = 1'b1;
        if (slots[SLOTS-1].valid) begin
          out_kind = tequ_pkg::KIND_FULL;
        end else begin
          out_kind = tequ_pkg::KIND_INSERT_OK;
          cell_op  = tequ_pkg::CELL_INSERT;
        end
        state_d = tequ_pkg::ST_IDLE;
      end
      tequ_pkg::ST_CANCEL: begin
        if (hit_chain[SLOTS]) begin
          cell_op = tequ_pkg::CELL_REMOVE;
          if (rm_cnt_q != '1) begin
            rm_cnt_d = rm_cnt_q + tequ_pkg::COUNT_W'(1);
          end
        end else begin
          out_load  = 1'b1;
          out_kind  = tequ_pkg::KIND_CANCELED;
          out_count = rm_cnt_q;
          state_d   = tequ_pkg::ST_IDLE;
        end
      end
      tequ_pkg::ST_DECAY: begin
        cell_op = tequ_pkg::CELL_DECAY;
        state_d = tequ_pkg::ST_FIRE;
      end
      tequ_pkg::ST_FIRE: begin
        if (!head_due) begin
          state_d = tequ_pkg::ST_IDLE;
        end else if (out_free) begin
          cell_op    = tequ_pkg::CELL_POP;
          out_load   = 1'b1;
          out_kind   = tequ_pkg::KIND_FIRED;
          out_owner  = slots[0].data.owner;
          out_cmd    = slots[0].data.command;
          out_tag    = slots[0].data.tag;
          out_last   = !next_due ||
                       (fire_cnt_q == tequ_pkg::FIRE_W'(tequ_pkg::MAX_RESULTS - 1));
          fire_cnt_d = fire_cnt_q + tequ_pkg::FIRE_W'(1);
          if (out_last) begin
            state_d = tequ_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = tequ_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tequ_pkg::ST_IDLE;
      rm_cnt_q    <= '0;
      fire_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rm_cnt_q   <= rm_cnt_d;
      fire_cnt_q <= fire_cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q.op      <= tequ_pkg::in_op_e'(operation_i);
      req_q.delay   <= delay_ticks_i;
      req_q.owner   <= owner_id_i;
      req_q.command <= command_i;
      req_q.tag     <= message_tag_i;
    end
    if (out_load) begin
      kind_q  <= out_kind;
      owner_q <= out_owner;
      cmd_q   <= out_cmd;
      tag_q   <= out_tag;
      count_q <= out_count;
      last_q  <= out_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = kind_q;
  assign fired_owner_o   = owner_q;
  assign fired_command_o = cmd_q;
  assign fired_tag_o     = tag_q;
  assign removed_count_o = count_q;
  assign last_of_run_o   = last_q;

  `TEQU_ASSERT(a_accept_empty_out, !in_stall_o |-> !out_valid_o, "request taken with result pending")
  `TEQU_ASSERT_NEVER(a_slots_packed, ((slot_vld >> 1) & ~slot_vld) != '0, "slot hole")
  `TEQU_ASSERT(a_single_last, out_valid_o && (result_kind_o != tequ_pkg::KIND_FIRED) |-> last_of_run_o, "single result not last")
  `TEQU_ASSERT_NEVER(a_fire_bound, fire_cnt_q > tequ_pkg::FIRE_W'(tequ_pkg::MAX_RESULTS), "too many fired")

endmodule

`default_nettype wire

// ===== rtl/core/tequ_cell.sv =====
`default_nettype none

module tequ_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tequ_pkg::cell_ctl_t ctl_i,
  input  wire tequ_pkg::slot_t     left_i,
  input  wire tequ_pkg::slot_t     right_i,
  input  wire logic                prev_keep_i,
  input  wire logic                hit_in_i,
  output logic                     keep_o,
  output logic                     hit_out_o,
  output tequ_pkg::slot_t          slot_o
);

  logic             valid_q, valid_d;
  tequ_pkg::entry_t data_q, data_d;
  tequ_pkg::entry_t new_entry;
  logic             hit;

  assign new_entry.remaining = ctl_i.req.delay;
  assign new_entry.owner     = ctl_i.req.owner;
  assign new_entry.command   = ctl_i.req.command;
  assign new_entry.tag       = ctl_i.req.tag;

  assign keep_o = valid_q && (data_q.remaining <= ctl_i.req.delay);
  assign hit    = valid_q && (data_q.owner == ctl_i.req.owner) &&
                  ((ctl_i.req.op == tequ_pkg::OP_CANCEL_ALL) ||
                   (data_q.command == ctl_i.req.command));
  assign hit_out_o = hit_in_i | hit;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    case (ctl_i.op)
      tequ_pkg::CELL_INSERT: begin
        if (!keep_o) begin
          if (prev_keep_i) begin
            valid_d = 1'b1;
            data_d  = new_entry;
          end else begin
            valid_d = left_i.valid;
            data_d  = left_i.data;
          end
        end
      end
      tequ_pkg::CELL_REMOVE: begin
        if (hit_out_o) begin
          valid_d = right_i.valid;
          data_d  = right_i.data;
        end
      end
      tequ_pkg::CELL_POP: begin
        valid_d = right_i.valid;
        data_d  = right_i.data;
      end
      tequ_pkg::CELL_DECAY: begin
        if (valid_q && (data_q.remaining != '0)) begin
          data_d.remaining = data_q.remaining - tequ_pkg::TIME_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign slot_o.valid = valid_q;
  assign slot_o.data  = data_q;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned SLOTS         = 16;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned RANDOM_TARGET = 330;
  localparam int unsigned TOTAL_TARGET  = 470;
  localparam int unsigned DRAIN_CYCLES  = 40;

  typedef struct packed {
    tequ_pkg::kind_e kind;
    logic [7:0]      owner;
    logic [15:0]     command;
    logic [15:0]     tag;
    logic [4:0]      removed;
    logic            last;
  } outcome_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  tequ_pkg::in_op_e  operation;
  logic [15:0]       delay_ticks;
  logic [7:0]        owner_id;
  logic [15:0]       command;
  logic [15:0]       message_tag;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        result_kind;
  logic [7:0]        fired_owner;
  logic [15:0]       fired_command;
  logic [15:0]       fired_tag;
  logic [4:0]        removed_count;
  logic              last_of_run;

  // Own copy of the event store, packed at the low end in deadline order.
  logic [15:0] ev_remaining [SLOTS];
  logic [7:0]  ev_owner     [SLOTS];
  logic [15:0] ev_command   [SLOTS];
  logic [15:0] ev_tag       [SLOTS];
  int unsigned ev_count = 0;

  outcome_t    awaited_outcomes [$];
  int unsigned failures    = 0;
  int unsigned sent_count  = 0;
  int unsigned idle_cycles = 0;
  bit          quiet       = 1'b0;

  always #2 clk = ~clk;

  timed_event_queue_with_cancel_unit #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .operation_i     (operation),
    .delay_ticks_i   (delay_ticks),
    .owner_id_i      (owner_id),
    .command_i       (command),
    .message_tag_i   (message_tag),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .result_kind_o   (result_kind),
    .fired_owner_o   (fired_owner),
    .fired_command_o (fired_command),
    .fired_tag_o     (fired_tag),
    .removed_count_o (removed_count),
    .last_of_run_o   (last_of_run)
  );

  function automatic void push_outcome(tequ_pkg::kind_e kind, logic [7:0] owner,
                                       logic [15:0] cmd, logic [15:0] tag,
                                       logic [4:0] removed, logic last);
    outcome_t o;
    o.kind    = kind;
    o.owner   = owner;
    o.command = cmd;
    o.tag     = tag;
    o.removed = removed;
    o.last    = last;
    awaited_outcomes.insert(awaited_outcomes.size(), o);
  endfunction

  function automatic void move_event(int unsigned dst, int unsigned src);
    ev_remaining[dst] = ev_remaining[src];
    ev_owner[dst]     = ev_owner[src];
    ev_command[dst]   = ev_command[src];
    ev_tag[dst]       = ev_tag[src];
  endfunction

  function automatic void step_event_model(tequ_pkg::in_op_e op, logic [15:0] delay,
                                           logic [7:0] owner, logic [15:0] cmd,
                                           logic [15:0] tag);
    int unsigned pos;
    int unsigned keep;
    int unsigned removed;
    int unsigned fired;
    case (op)
      tequ_pkg::OP_INSERT: begin
        if (ev_count >= SLOTS) begin
          push_outcome(tequ_pkg::KIND_FULL, '0, '0, '0, '0, 1'b1);
        end else begin
          pos = 0;
          // goes after every event due no later
          while (pos < ev_count && ev_remaining[pos] <= delay) pos++;
          for (int i = ev_count; i > pos; i--) move_event(i, i - 1);
          ev_remaining[pos] = delay;
          ev_owner[pos]     = owner;
          ev_command[pos]   = cmd;
          ev_tag[pos]       = tag;
          ev_count++;
          push_outcome(tequ_pkg::KIND_INSERT_OK, '0, '0, '0, '0, 1'b1);
        end
      end
      tequ_pkg::OP_CANCEL_CMD, tequ_pkg::OP_CANCEL_ALL: begin
        keep    = 0;
        removed = 0;
        for (int unsigned i = 0; i < ev_count; i++) begin
          if (ev_owner[i] == owner &&
              (op == tequ_pkg::OP_CANCEL_ALL || ev_command[i] == cmd)) begin
            removed++;
          end else begin
            if (keep != i) move_event(keep, i);
            keep++;
          end
        end
        ev_count = keep;
        if (removed > 31) removed = 31;
        push_outcome(tequ_pkg::KIND_CANCELED, '0, '0, '0, 5'(removed), 1'b1);
      end
      default: begin
        for (int unsigned i = 0; i < ev_count; i++) begin
          if (ev_remaining[i] != 16'd0) ev_remaining[i] = ev_remaining[i] - 16'd1;
        end
        fired = 0;
        while (fired < ev_count && fired < tequ_pkg::MAX_RESULTS &&
               ev_remaining[fired] == 16'd0) fired++;
        for (int unsigned i = 0; i < fired; i++) begin
          push_outcome(tequ_pkg::KIND_FIRED, ev_owner[i], ev_command[i], ev_tag[i], '0,
                       i + 1 == fired);
        end
        for (int unsigned i = fired; i < ev_count; i++) move_event(i - fired, i);
        ev_count = ev_count - fired;
      end
    endcase
  endfunction

  task automatic input_gap();
    int unsigned n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 12);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_request(tequ_pkg::in_op_e op, logic [15:0] delay, logic [7:0] owner,
                              logic [15:0] cmd, logic [15:0] tag);
    input_gap();
    @(negedge clk);
    in_valid    <= 1'b1;
    operation   <= op;
    delay_ticks <= delay;
    owner_id    <= owner;
    command     <= cmd;
    message_tag <= tag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_event_model(op, delay, owner, cmd, tag);
    sent_count++;
  endtask

  function automatic logic [15:0] rand_delay();
    if ($urandom_range(0, 99) < 85) return 16'($urandom_range(0, 6));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [7:0] rand_owner();
    if ($urandom_range(0, 99) < 80) return 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] rand_cmd();
    if ($urandom_range(0, 99) < 70) return 16'($urandom_range(0, 3));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] rand16();
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic run_random_sequence();
    int unsigned pick;
    int unsigned n;
    int unsigned idx;
    logic [7:0]  own;
    logic [15:0] cmd;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      n = $urandom_range(1, 4);
      repeat (n) send_request(tequ_pkg::OP_INSERT, rand_delay(), rand_owner(), rand_cmd(),
                              rand16());
      n = $urandom_range(1, 6);
      repeat (n) send_request(tequ_pkg::OP_TICK, rand16(), 8'($urandom_range(0, 255)),
                              rand16(), rand16());
    end else if (pick < 70) begin
      if (ev_count > 0) begin
        idx = $urandom_range(0, ev_count - 1);
        own = ev_owner[idx];
        cmd = ev_command[idx];
      end else begin
        own = rand_owner();
        cmd = rand_cmd();
      end
      send_request($urandom_range(0, 1) ? tequ_pkg::OP_CANCEL_ALL : tequ_pkg::OP_CANCEL_CMD,
                   rand16(), own, cmd, rand16());
    end else if (pick < 95) begin
      send_request(tequ_pkg::in_op_e'($urandom_range(0, 3)), rand16(),
                   8'($urandom_range(0, 255)), rand16(), rand16());
    end else begin
      // fill the store with one owner's events, overflow it, then cancel that owner or tick
      own = rand_owner();
      while (ev_count < SLOTS) begin
        send_request(tequ_pkg::OP_INSERT, 16'($urandom_range(0, 2)), own, rand_cmd(),
                     rand16());
      end
      send_request(tequ_pkg::OP_INSERT, rand_delay(), rand_owner(), rand_cmd(), rand16());
      if ($urandom_range(0, 1)) begin
        send_request(tequ_pkg::OP_CANCEL_ALL, rand16(), own, rand16(), rand16());
      end else begin
        repeat (3) send_request(tequ_pkg::OP_TICK, rand16(), 8'($urandom_range(0, 255)),
                                rand16(), rand16());
      end
    end
  endtask

  task automatic test_directed_ops();
    send_request(tequ_pkg::OP_CANCEL_CMD, 16'h0000, 8'h00, 16'h0000, 16'h0000);
    send_request(tequ_pkg::OP_TICK, 16'hffff, 8'hff, 16'hffff, 16'hffff);
    send_request(tequ_pkg::OP_INSERT, 16'd1, 8'h01, 16'h0010, 16'h000a);
    send_request(tequ_pkg::OP_INSERT, 16'd0, 8'h02, 16'h0020, 16'h000b);
    send_request(tequ_pkg::OP_INSERT, 16'd1, 8'h03, 16'h0030, 16'h000c);
    send_request(tequ_pkg::OP_INSERT, 16'hffff, 8'hff, 16'hffff, 16'hffff);
    send_request(tequ_pkg::OP_INSERT, 16'd0, 8'h00, 16'h0000, 16'h0000);
    send_request(tequ_pkg::OP_TICK, 16'h0000, 8'h00, 16'h0000, 16'h0000);
    send_request(tequ_pkg::OP_TICK, 16'h0000, 8'h00, 16'h0000, 16'h0000);
    send_request(tequ_pkg::OP_CANCEL_CMD, 16'h0000, 8'hff, 16'h1234, 16'h0000);
    send_request(tequ_pkg::OP_CANCEL_ALL, 16'h0000, 8'hff, 16'h0000, 16'h0000);
    send_request(tequ_pkg::OP_INSERT, 16'd3, 8'h05, 16'h0001, 16'h0101);
    send_request(tequ_pkg::OP_INSERT, 16'd2, 8'h05, 16'h0002, 16'h0102);
    send_request(tequ_pkg::OP_INSERT, 16'd2, 8'h06, 16'h0001, 16'h0103);
    send_request(tequ_pkg::OP_CANCEL_CMD, 16'h0000, 8'h05, 16'h0001, 16'h0000);
    send_request(tequ_pkg::OP_TICK, 16'h0000, 8'h00, 16'h0000, 16'h0000);
    send_request(tequ_pkg::OP_TICK, 16'h0000, 8'h00, 16'h0000, 16'h0000);
  endtask

  task automatic test_full_store();
    for (int i = 0; i < SLOTS; i++) begin
      send_request(tequ_pkg::OP_INSERT, 16'd0, 8'h09, 16'(i), 16'(16'h8000 + i));
    end
    send_request(tequ_pkg::OP_INSERT, 16'hffff, 8'hff, 16'hffff, 16'hffff);
    send_request(tequ_pkg::OP_TICK, 16'h0000, 8'h00, 16'h0000, 16'h0000);
  endtask

  task automatic test_random_traffic();
    while (sent_count < RANDOM_TARGET) run_random_sequence();
  endtask

  task automatic test_random_burst();
    quiet = 1'b1;
    while (sent_count < TOTAL_TARGET) run_random_sequence();
  endtask

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic void check_field(string name, logic [15:0] expv, logic [15:0] actv);
    if (actv !== expv) note_failure($sformatf("%s expected %0h got %0h", name, expv, actv));
  endfunction

  always @(posedge clk) begin
    outcome_t exp_o;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_outcomes.size() == 0) begin
        note_failure($sformatf("unexpected result, kind %0d", result_kind));
      end else begin
        exp_o = awaited_outcomes.pop_front();
        check_field("result_kind", 16'(exp_o.kind), 16'(result_kind));
        check_field("fired_owner", 16'(exp_o.owner), 16'(fired_owner));
        check_field("fired_command", exp_o.command, fired_command);
        check_field("fired_tag", exp_o.tag, fired_tag);
        check_field("removed_count", 16'(exp_o.removed), 16'(removed_count));
        check_field("last_of_run", 16'(exp_o.last), 16'(last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timed_event_queue_with_cancel_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n;
    out_stall = 1'b0;
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 12);
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
        @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        @(negedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    operation   = tequ_pkg::OP_TICK;
    delay_ticks = '0;
    owner_id    = '0;
    command     = '0;
    message_tag = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_ops();
    test_full_store();
    test_random_traffic();
    test_random_burst();

    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && awaited_outcomes.size() == 0) begin
      $display("timed_event_queue_with_cancel_unit regression: pass");
    end else begin
      $display("timed_event_queue_with_cancel_unit regression: fail");
    end
    $finish;
  end

endmodule
